// ----- hdl/ewsm_pkg.sv -----
package ewsm_pkg;

   // default table size
   localparam int TABLE_DEPTH = 16;

   // request kinds
   localparam logic [1:0] REQ_WAIT    = 2'd0;
   localparam logic [1:0] REQ_SIGNAL  = 2'd1;
   localparam logic [1:0] REQ_RELEASE = 2'd2;

   // result status codes
   localparam logic [3:0] ST_NO_WAIT    = 4'd0;
   localparam logic [3:0] ST_CONSUMED   = 4'd1;
   localparam logic [3:0] ST_QUEUED     = 4'd2;
   localparam logic [3:0] ST_WOKEN      = 4'd3;
   localparam logic [3:0] ST_SIG_QUEUED = 4'd4;
   localparam logic [3:0] ST_DROPPED    = 4'd5;
   localparam logic [3:0] ST_FULL       = 4'd6;
   localparam logic [3:0] ST_RELEASED   = 4'd7;
   localparam logic [3:0] ST_INVALID    = 4'd8;

   // what the cells look for in the compare cycle
   typedef enum logic [1:0] {
      SEARCH_NONE,
      SEARCH_SIGNAL,
      SEARCH_WAITER,
      SEARCH_SLOT
   } search_type;

   // payload of one table entry
   typedef struct packed {
      logic        is_signal;
      logic        signaled;
      logic [31:0] code;
      logic [31:0] events;
   } entry_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      search_type  search;
      logic        sample;
      logic        remove;
      logic        wake;
      logic        insert;
      logic        ins_is_signal;
      logic [31:0] code;
      logic [31:0] mask;
   } cell_ctl_type;

   // data of the selected entry, gathered along the chain
   typedef struct packed {
      logic        signaled;
      logic [31:0] events;
   } pick_type;

endpackage

// ----- hdl/event_waiter_signal_matcher.sv -----
// Matches wait requests against pending signals in one age-ordered table held
// as a chain of cells, oldest entry in the first cell. A request goes from its
// accepting beat to its result in order: it is registered, every cell compares
// its entry with the request, and then the first hit along the chain is
// selected and the table is updated (a removed entry closes the gap by every
// later cell taking its neighbor's contents). The result sits in an output
// register; the next request is taken while it waits, but its update cycle
// stalls until the result beat has gone. Waiter slot numbers are the lowest
// free slot number, reported in 4 bits. Timeouts are not timed here: they come
// in as release requests. No clearing pass is needed after reset.
module event_waiter_signal_matcher #(
   parameter int TABLE_DEPTH = ewsm_pkg::TABLE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // timeout_ms[31:0], event_code[63:32], event_mask[95:64], release_slot[99:96]
   input  logic [103:0]  req_tdata,
   // req_type[1:0]
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // delivered_events[31:0], slot[35:32]
   output logic [39:0]   rsp_tdata,
   // status[3:0]
   output logic [3:0]    rsp_tuser
);

   localparam int SLOT_W = $clog2(TABLE_DEPTH);

   typedef enum logic [1:0] {S_IDLE, S_MATCH, S_APPLY} state_type;

   state_type         state_ff;
   logic [1:0]        type_ff;
   logic              tmo_nz_ff;
   logic [31:0]       code_ff, mask_ff;
   logic [3:0]        rel_ff;
   logic              rsp_valid_ff;
   logic [3:0]        status_ff;
   logic [31:0]       events_ff;
   logic [3:0]        slot_ff;

   ewsm_pkg::cell_ctl_type ctl;
   ewsm_pkg::search_type   search;
   logic [31:0]       rel_wide, slot_wide;
   logic              rel_ok, go, any_hit, full, is_wait;
   logic [SLOT_W-1:0] rel_idx, free_idx, sel_slot, slot_idx;
   logic [3:0]        status;
   logic [31:0]       events;
   logic              remove, wake, insert, ins_sig, alloc, dealloc;

   logic                valid_w [TABLE_DEPTH];
   ewsm_pkg::entry_type entry_w [TABLE_DEPTH];
   logic [SLOT_W-1:0]   slot_w  [TABLE_DEPTH];
   logic                seen_w  [TABLE_DEPTH+1];
   ewsm_pkg::pick_type  pick_w  [TABLE_DEPTH+1];
   logic [SLOT_W-1:0]   pslot_w [TABLE_DEPTH+1];

   // request decode
   assign rel_wide = {28'd0, rel_ff};
   assign rel_ok   = (rel_wide < 32'(TABLE_DEPTH));
   assign rel_idx  = rel_wide[SLOT_W-1:0];
   assign is_wait  = (mask_ff != 32'd0) && tmo_nz_ff;

   always_comb begin
      unique case (type_ff)
         ewsm_pkg::REQ_WAIT:    search = is_wait ? ewsm_pkg::SEARCH_SIGNAL : ewsm_pkg::SEARCH_NONE;
         ewsm_pkg::REQ_SIGNAL:  search = ewsm_pkg::SEARCH_WAITER;
         ewsm_pkg::REQ_RELEASE: search = rel_ok ? ewsm_pkg::SEARCH_SLOT : ewsm_pkg::SEARCH_NONE;
         default:               search = ewsm_pkg::SEARCH_NONE;
      endcase
   end

   assign go       = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_tready);
   assign any_hit  = seen_w[TABLE_DEPTH];
   assign sel_slot = pslot_w[TABLE_DEPTH];

   // outcome of the request once the cells have compared
   always_comb begin
      status   = ewsm_pkg::ST_INVALID;
      events   = 32'd0;
      slot_idx = '0;
      remove   = 1'b0;
      wake     = 1'b0;
      insert   = 1'b0;
      ins_sig  = 1'b0;
      unique case (type_ff)
         ewsm_pkg::REQ_WAIT: begin
            if (!is_wait) begin
               status = ewsm_pkg::ST_NO_WAIT;
            end else if (any_hit) begin
               status = ewsm_pkg::ST_CONSUMED;
               events = pick_w[TABLE_DEPTH].events & mask_ff;
               remove = 1'b1;
            end else if (full) begin
               status = ewsm_pkg::ST_FULL;
            end else begin
               status   = ewsm_pkg::ST_QUEUED;
               slot_idx = free_idx;
               insert   = 1'b1;
            end
         end
         ewsm_pkg::REQ_SIGNAL: begin
            if (any_hit) begin
               status   = ewsm_pkg::ST_WOKEN;
               events   = pick_w[TABLE_DEPTH].events & mask_ff;
               slot_idx = sel_slot;
               wake     = 1'b1;
            end else if (code_ff == 32'd0) begin
               status = ewsm_pkg::ST_DROPPED;
            end else if (full) begin
               status = ewsm_pkg::ST_FULL;
            end else begin
               status  = ewsm_pkg::ST_SIG_QUEUED;
               insert  = 1'b1;
               ins_sig = 1'b1;
            end
         end
         ewsm_pkg::REQ_RELEASE: begin
            if (any_hit) begin
               status   = ewsm_pkg::ST_RELEASED;
               events   = pick_w[TABLE_DEPTH].signaled ? pick_w[TABLE_DEPTH].events : 32'd0;
               slot_idx = sel_slot;
               remove   = 1'b1;
            end
         end
         default: begin
            status = ewsm_pkg::ST_INVALID;
         end
      endcase
   end

   assign alloc   = go & insert;
   assign dealloc = go & remove;

   // broadcast to the cells
   always_comb begin
      ctl.search        = search;
      ctl.sample        = (state_ff == S_MATCH);
      ctl.remove        = go & remove;
      ctl.wake          = go & wake;
      ctl.insert        = go & insert;
      ctl.ins_is_signal = ins_sig;
      ctl.code          = code_ff;
      ctl.mask          = mask_ff;
   end

   assign slot_wide = 32'(slot_idx);

   // chain ends
   assign seen_w[0]  = 1'b0;
   assign pick_w[0]  = '0;
   assign pslot_w[0] = '0;

   // row of cells, oldest first
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic                pv, nv;
      ewsm_pkg::entry_type ne;
      logic [SLOT_W-1:0]   ns;

      if (g == 0) begin : g_head
         assign pv = 1'b1;
      end else begin : g_mid
         assign pv = valid_w[g-1];
      end

      if (g == TABLE_DEPTH - 1) begin : g_tail
         assign nv = 1'b0;
         assign ne = '0;
         assign ns = '0;
      end else begin : g_body
         assign nv = valid_w[g+1];
         assign ne = entry_w[g+1];
         assign ns = slot_w[g+1];
      end

      ewsm_cell #(
         .SLOT_W(SLOT_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .rel_idx       (rel_idx),
         .ins_slot      (free_idx),
         .prev_valid    (pv),
         .seen_in       (seen_w[g]),
         .pick_in       (pick_w[g]),
         .pick_slot_in  (pslot_w[g]),
         .next_valid    (nv),
         .next_entry    (ne),
         .next_slot     (ns),
         .valid         (valid_w[g]),
         .entry         (entry_w[g]),
         .slot          (slot_w[g]),
         .seen_out      (seen_w[g+1]),
         .pick_out      (pick_w[g+1]),
         .pick_slot_out (pslot_w[g+1])
      );
   end

   // slot numbers in use
   ewsm_alloc #(
      .DEPTH (TABLE_DEPTH),
      .SLOT_W(SLOT_W)
   ) u_alloc (
      .clock      (clock),
      .reset      (reset),
      .sample     (ctl.sample),
      .alloc      (alloc),
      .dealloc    (dealloc),
      .dealloc_idx(sel_slot),
      .free_idx   (free_idx),
      .full       (full)
   );

   // sequencer with request and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result register: loaded on update, emptied when its beat goes
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff  <= S_MATCH;
                  type_ff   <= req_tuser;
                  tmo_nz_ff <= (req_tdata[31:0] != 32'd0);
                  code_ff   <= req_tdata[63:32];
                  mask_ff   <= req_tdata[95:64];
                  rel_ff    <= req_tdata[99:96];
               end
            end
            S_MATCH: begin
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               if (go) begin
                  state_ff     <= S_IDLE;
                  status_ff    <= status;
                  events_ff    <= events;
                  slot_ff      <= slot_wide[3:0];
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, slot_ff, events_ff};
   assign rsp_tuser  = status_ff;

endmodule

// ----- hdl/ewsm_cell.sv -----
module ewsm_cell #(
   parameter int SLOT_W = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ewsm_pkg::cell_ctl_type ctl,
   input  logic [SLOT_W-1:0]     rel_idx,
   input  logic [SLOT_W-1:0]     ins_slot,
   // older neighbor
   input  logic                  prev_valid,
   input  logic                  seen_in,
   input  ewsm_pkg::pick_type    pick_in,
   input  logic [SLOT_W-1:0]     pick_slot_in,
   // younger neighbor
   input  logic                  next_valid,
   input  ewsm_pkg::entry_type   next_entry,
   input  logic [SLOT_W-1:0]     next_slot,
   // own state toward neighbors
   output logic                  valid,
   output ewsm_pkg::entry_type   entry,
   output logic [SLOT_W-1:0]     slot,
   output logic                  seen_out,
   output ewsm_pkg::pick_type    pick_out,
   output logic [SLOT_W-1:0]     pick_slot_out
);

   logic                valid_ff, valid_in;
   logic                hit_ff, hit_in;
   ewsm_pkg::entry_type entry_ff, entry_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                overlap, code_ok, hit_now, first;

   // compare against the broadcast request
   always_comb begin
      overlap = |(entry_ff.events & ctl.mask);
      code_ok = (entry_ff.code == 32'd0) || (entry_ff.code == ctl.code);
      unique case (ctl.search)
         ewsm_pkg::SEARCH_SIGNAL: hit_now = valid_ff & entry_ff.is_signal & overlap & code_ok;
         ewsm_pkg::SEARCH_WAITER: hit_now = valid_ff & ~entry_ff.is_signal & overlap & code_ok;
         ewsm_pkg::SEARCH_SLOT:   hit_now = valid_ff & ~entry_ff.is_signal & (slot_ff == rel_idx);
         default:                 hit_now = 1'b0;
      endcase
   end

   // oldest hit wins: first hit seen along the chain
   assign first    = hit_ff & ~seen_in;
   assign seen_out = seen_in | hit_ff;

   assign pick_out.events    = pick_in.events | (first ? entry_ff.events : 32'd0);
   assign pick_out.signaled  = pick_in.signaled | (first & entry_ff.signaled);
   assign pick_slot_out      = pick_slot_in | (first ? slot_ff : '0);

   // next state: compact on remove, narrow on wake, fill first empty cell on insert
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      slot_in  = slot_ff;
      hit_in   = ctl.sample ? hit_now : hit_ff;
      if (ctl.remove && seen_out) begin
         valid_in = next_valid;
         entry_in = next_entry;
         slot_in  = next_slot;
      end else if (ctl.wake && first) begin
         entry_in.events   = entry_ff.events & ctl.mask;
         entry_in.signaled = 1'b1;
      end else if (ctl.insert && !valid_ff && prev_valid) begin
         valid_in           = 1'b1;
         entry_in.is_signal = ctl.ins_is_signal;
         entry_in.signaled  = 1'b0;
         entry_in.code      = ctl.code;
         entry_in.events    = ctl.mask;
         slot_in            = ins_slot;
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      slot_ff  <= slot_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;
   assign slot  = slot_ff;

endmodule

// ----- hdl/ewsm_alloc.sv -----
module ewsm_alloc #(
   parameter int DEPTH  = 16,
   parameter int SLOT_W = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              sample,
   input  logic              alloc,
   input  logic              dealloc,
   input  logic [SLOT_W-1:0] dealloc_idx,
   output logic [SLOT_W-1:0] free_idx,
   output logic              full
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DEPTH-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] free_idx_ff, lowest;

   // lowest free slot number
   always_comb begin
      lowest = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            lowest = SLOT_W'(i);
         end
      end
   end

   // occupancy update
   always_comb begin
      used_in  = used_ff;
      count_in = count_ff;
      if (alloc) begin
         used_in[free_idx_ff] = 1'b1;
         count_in             = count_ff + CNT_W'(1);
      end else if (dealloc) begin
         used_in[dealloc_idx] = 1'b0;
         count_in             = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         count_ff <= '0;
      end else begin
         used_ff  <= used_in;
         count_ff <= count_in;
      end
   end

   // free slot captured in the compare cycle
   always_ff @(posedge clock) begin
      if (sample) begin
         free_idx_ff <= lowest;
      end
   end

   assign free_idx = free_idx_ff;
   assign full     = (count_ff == CNT_W'(DEPTH));

endmodule

// ----- hdl/ewsm_checker.sv -----
module ewsm_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [39:0]  rsp_tdata,
   input logic [3:0]   rsp_tuser
);

   // a held result beat keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // one request in flight: no beat right after an accepted one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in flight");

   // status stays within the defined codes
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= ewsm_pkg::ST_INVALID)
      else $error("undefined status code");

   // only woken, queued and released results carry a slot
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ewsm_pkg::ST_WOKEN && rsp_tuser != ewsm_pkg::ST_QUEUED
      && rsp_tuser != ewsm_pkg::ST_RELEASED |-> rsp_tdata[35:32] == 4'd0)
      else $error("slot reported for a result without one");

   // results that deliver nothing carry no events
   a_events_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ewsm_pkg::ST_NO_WAIT || rsp_tuser == ewsm_pkg::ST_QUEUED
      || rsp_tuser == ewsm_pkg::ST_SIG_QUEUED || rsp_tuser == ewsm_pkg::ST_DROPPED
      || rsp_tuser == ewsm_pkg::ST_FULL || rsp_tuser == ewsm_pkg::ST_INVALID)
      |-> rsp_tdata[31:0] == 32'd0)
      else $error("events reported for a result without delivery");

endmodule

bind event_waiter_signal_matcher ewsm_checker u_ewsm_checker (.*);

// ----- dv/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         DEPTH       = ewsm_pkg::TABLE_DEPTH;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   // one request beat, fields as the block sees them
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] timeout_ms;
      logic [31:0] code;
      logic [31:0] mask;
      logic [3:0]  release_slot;
   } request_type;

   // one result beat
   typedef struct packed {
      logic [3:0]  status;
      logic [31:0] events;
      logic [3:0]  slot;
   } outcome_type;

   // age-ordered waiter and signal table, plus the outcomes still owed by the block
   class table_model_type;
      bit          used      [DEPTH];
      bit          is_signal [DEPTH];
      bit          signaled  [DEPTH];
      logic [31:0] code      [DEPTH];
      logic [31:0] events    [DEPTH];
      int          age       [DEPTH];
      outcome_type expected_results [$];
      int          errors;

      function int occupancy();
         int n = 0;
         foreach (used[i]) if (used[i]) n++;
         return n;
      endfunction

      function int lowest_free();
         for (int i = 0; i < DEPTH; i++) if (!used[i]) return i;
         return -1;
      endfunction

      // oldest live entry of one kind whose events overlap and whose code fits
      function int oldest_hit(bit want_signal, logic [31:0] key, logic [31:0] mask);
         int best = -1;
         for (int i = 0; i < DEPTH; i++) begin
            if (!used[i] || is_signal[i] != want_signal) continue;
            if ((events[i] & mask) == '0) continue;
            if (code[i] != '0 && code[i] != key) continue;
            if (best < 0 || age[i] < age[best]) best = i;
         end
         return best;
      endfunction

      // free an entry and close the gap in the age order
      function void drop_cell(int c);
         int r = age[c];
         used[c]     = 1'b0;
         signaled[c] = 1'b0;
         for (int i = 0; i < DEPTH; i++) if (used[i] && age[i] > r) age[i]--;
      endfunction

      function void fill_cell(int c, bit sig, logic [31:0] key, logic [31:0] ev);
         age[c]       = occupancy();
         used[c]      = 1'b1;
         is_signal[c] = sig;
         code[c]      = key;
         events[c]    = ev;
         signaled[c]  = 1'b0;
      endfunction

      // apply one accepted request and queue the outcome it must produce
      function void note_request(request_type rq);
         outcome_type res;
         int          c;
         int          rel;
         rel        = int'(rq.release_slot);
         res.status = ewsm_pkg::ST_INVALID;
         res.events = '0;
         res.slot   = '0;
         case (rq.kind)
            ewsm_pkg::REQ_WAIT: begin
               if (rq.mask == '0 || rq.timeout_ms == '0) begin
                  res.status = ewsm_pkg::ST_NO_WAIT;
               end else begin
                  c = oldest_hit(1'b1, rq.code, rq.mask);
                  if (c >= 0) begin
                     res.events = events[c] & rq.mask;
                     drop_cell(c);
                     res.status = ewsm_pkg::ST_CONSUMED;
                  end else begin
                     c = lowest_free();
                     if (c < 0) begin
                        res.status = ewsm_pkg::ST_FULL;
                     end else begin
                        fill_cell(c, 1'b0, rq.code, rq.mask);
                        res.status = ewsm_pkg::ST_QUEUED;
                        res.slot   = c[3:0];
                     end
                  end
               end
            end
            ewsm_pkg::REQ_SIGNAL: begin
               c = oldest_hit(1'b0, rq.code, rq.mask);
               if (c >= 0) begin
                  signaled[c] = 1'b1;
                  events[c]   = events[c] & rq.mask;
                  res.events  = events[c];
                  res.status  = ewsm_pkg::ST_WOKEN;
                  res.slot    = c[3:0];
               end else if (rq.code == '0) begin
                  res.status = ewsm_pkg::ST_DROPPED;
               end else begin
                  c = lowest_free();
                  if (c < 0) begin
                     res.status = ewsm_pkg::ST_FULL;
                  end else begin
                     fill_cell(c, 1'b1, rq.code, rq.mask);
                     res.status = ewsm_pkg::ST_SIG_QUEUED;
                  end
               end
            end
            ewsm_pkg::REQ_RELEASE: begin
               if (rel < DEPTH && used[rel] && !is_signal[rel]) begin
                  res.events = signaled[rel] ? events[rel] : '0;
                  drop_cell(rel);
                  res.status = ewsm_pkg::ST_RELEASED;
                  res.slot   = rq.release_slot;
               end
            end
            default: ;
         endcase
         expected_results.push_back(res);
      endfunction

      // compare one result beat with the oldest outstanding outcome
      function void check_result(logic [3:0] status, logic [31:0] ev, logic [3:0] slot);
         outcome_type want;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result status %0d events %h slot %0d",
                     $time, status, ev, slot);
            return;
         end
         want = expected_results.pop_front();
         if (status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d got %0d", $time, want.status, status);
         end
         if (ev !== want.events) begin
            errors++;
            $display("%0t: events expected %h got %h", $time, want.events, ev);
         end
         if (slot !== want.slot) begin
            errors++;
            $display("%0t: slot expected %0d got %0d", $time, want.slot, slot);
         end
      endfunction
   endclass

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   // timeout_ms[31:0], event_code[63:32], event_mask[95:64], release_slot[99:96]
   logic [103:0]  req_tdata  = '0;
   // req_type[1:0]
   logic [1:0]    req_tuser  = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   // delivered_events[31:0], slot[35:32]
   logic [39:0]   rsp_tdata;
   // status[3:0]
   logic [3:0]    rsp_tuser;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   table_model_type match_table = new;

   event_waiter_signal_matcher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // response side: random backpressure and checking of every result beat
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            match_table.check_result(rsp_tuser, rsp_tdata[31:0], rsp_tdata[35:32]);
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic request_type make_req(logic [1:0] kind, logic [31:0] tmo,
                                            logic [31:0] key, logic [31:0] mask,
                                            logic [3:0] rel);
      request_type rq;
      rq.kind         = kind;
      rq.timeout_ms   = tmo;
      rq.code         = key;
      rq.mask         = mask;
      rq.release_slot = rel;
      return rq;
   endfunction

   // random request; codes and masks come from narrow pools so that matches are common
   function automatic request_type random_request();
      request_type rq;
      int          n;
      int          roll;
      int          rel_weight;
      int          waiter_slots [$];
      n          = match_table.occupancy();
      rel_weight = (n > 12) ? 40 : 14;
      roll       = $urandom_range(99);
      rq.timeout_ms   = $urandom;
      rq.release_slot = 4'($urandom_range(15));
      case ($urandom_range(9))
         0, 1, 2: rq.code = '0;
         3, 4, 5: rq.code = 32'd1;
         6, 7:    rq.code = 32'd2;
         8:       rq.code = 32'd3;
         default: rq.code = $urandom;
      endcase
      case ($urandom_range(19))
         0:       rq.mask = '0;
         1:       rq.mask = '1;
         2, 3:    rq.mask = $urandom;
         4, 5:    rq.mask = 32'd1 << $urandom_range(31);
         default: rq.mask = $urandom_range(1, 15);
      endcase
      case ($urandom_range(19))
         0:       rq.timeout_ms = '0;
         1:       rq.timeout_ms = '1;
         default: if (rq.timeout_ms == '0) rq.timeout_ms = 32'd1;
      endcase
      if (roll < 2) begin
         rq.kind = REQ_UNKNOWN;
      end else if (roll < 2 + rel_weight) begin
         rq.kind = ewsm_pkg::REQ_RELEASE;
         // mostly aim at a live waiter, otherwise any slot
         foreach (match_table.used[i])
            if (match_table.used[i] && !match_table.is_signal[i]) waiter_slots.push_back(i);
         if (waiter_slots.size() > 0 && $urandom_range(9) < 8)
            rq.release_slot = 4'(waiter_slots[$urandom_range(waiter_slots.size() - 1)]);
      end else if (roll < 2 + rel_weight + (98 - rel_weight) / 2) begin
         rq.kind = ewsm_pkg::REQ_WAIT;
      end else begin
         rq.kind = ewsm_pkg::REQ_SIGNAL;
      end
      return rq;
   endfunction

   // drive one request beat, idling first at random, and predict it on acceptance
   task automatic push_request(request_type rq);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.kind;
      req_tdata  <= {4'b0, rq.release_slot, rq.mask, rq.code, rq.timeout_ms};
      do @(posedge clock); while (!req_tready);
      match_table.note_request(rq);
   endtask

   // main sequence
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // immediate returns and bad requests
      push_request(make_req(ewsm_pkg::REQ_WAIT, 32'd0, 32'd1, 32'hFFFF_FFFF, 4'd0));
      push_request(make_req(ewsm_pkg::REQ_WAIT, 32'hFFFF_FFFF, 32'd1, 32'd0, 4'd0));
      push_request(make_req(ewsm_pkg::REQ_RELEASE, 32'd5, 32'd0, 32'd1, 4'd0));
      push_request(make_req(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15));
      // zero-code signal with nobody waiting is lost, a coded one is held
      push_request(make_req(ewsm_pkg::REQ_SIGNAL, 32'd1, 32'd0, 32'd1, 4'd0));
      push_request(make_req(ewsm_pkg::REQ_SIGNAL, 32'd1, 32'd5, 32'h8000_0000, 4'd0));
      push_request(make_req(ewsm_pkg::REQ_WAIT, 32'hFFFF_FFFF, 32'd5, 32'hFFFF_FFFF, 4'd0));
      // any-code waiter woken twice, then released with its narrowed events
      push_request(make_req(ewsm_pkg::REQ_WAIT, 32'd10, 32'd0, 32'h3, 4'd0));
      push_request(make_req(ewsm_pkg::REQ_SIGNAL, 32'd0, 32'd7, 32'h2, 4'd0));
      push_request(make_req(ewsm_pkg::REQ_SIGNAL, 32'd0, 32'd9, 32'h6, 4'd0));
      push_request(make_req(ewsm_pkg::REQ_RELEASE, 32'd0, 32'd0, 32'd0, 4'd0));
      // releasing a held signal is refused
      push_request(make_req(ewsm_pkg::REQ_SIGNAL, 32'd0, 32'hFFFF_FFFF, 32'd1, 4'd0));
      push_request(make_req(ewsm_pkg::REQ_RELEASE, 32'd0, 32'd0, 32'd0, 4'd0));
      // fill the table, wake the oldest of equals, then overflow both ways
      for (int i = 1; i < DEPTH; i++)
         push_request(make_req(ewsm_pkg::REQ_WAIT, 32'd3, 32'h0000_AAAA, 32'h100, 4'(i)));
      push_request(make_req(ewsm_pkg::REQ_SIGNAL, 32'd0, 32'h0000_AAAA, 32'h100, 4'd0));
      push_request(make_req(ewsm_pkg::REQ_WAIT, 32'd3, 32'h55, 32'h8000, 4'd0));
      push_request(make_req(ewsm_pkg::REQ_SIGNAL, 32'd0, 32'h1234, 32'h200, 4'd0));

      // random traffic under each flow-control pattern
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = (p == 1) ? 88 : (p == 3) ? 29 : 0;
         recv_stall_pct = (p == 2) ? 88 : (p == 3) ? 29 : 0;
         repeat (490) push_request(random_request());
      end
      req_tvalid <= 1'b0;

      // drain
      while (match_table.expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (match_table.errors == 0 && match_table.expected_results.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule
